FILE: rtl/sard_pkg.sv
// Package for the serial ADC sample reader.
// It holds the shared types, field widths and register indexes.
// It has no dependencies. Every other file in rtl/ uses it.
`timescale 1ns / 1ps

package sard_pkg;

  localparam int unsigned SampleW       = 12;
  localparam int unsigned HalfW         = 16;
  localparam int unsigned ChanW         = 3;
  localparam int unsigned ClkIdxW       = 5;
  localparam int unsigned CfgIdxW       = 2;
  localparam int unsigned CfgDataW      = 16;

  localparam int unsigned CommandClocks = 6;
  localparam int unsigned ReadClocks    = 13;
  localparam int unsigned TotalClocks   = CommandClocks + ReadClocks;

  localparam logic [HalfW-1:0] ResetHalfPeriod = HalfW'(1500);

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgHalfPeriod = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgChannel    = CfgIdxW'(1);

  typedef struct packed {
    logic start_req;
    logic miso_level;
  } in_item_t;

  typedef struct packed {
    logic               chip_select_n;
    logic               serial_clock;
    logic               mosi_level;
    logic               busy_res;
    logic               done_res;
    logic [SampleW-1:0] sample;
  } out_item_t;

  typedef struct packed {
    logic [HalfW-1:0] half_period_ticks;
    logic [ChanW-1:0] channel;
  } cfg_t;

endpackage

FILE: rtl/sard_cfg.sv
// Configuration registers of the serial ADC sample reader.
// It depends on sard_pkg for the register indexes and the cfg_t type.
`timescale 1ns / 1ps

module sard_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sard_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [sard_pkg::CfgDataW-1:0] cfg_data_i,
  output sard_pkg::cfg_t                cfg_o
);

  sard_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        sard_pkg::CfgHalfPeriod: begin
          cfg_d.half_period_ticks = cfg_data_i[sard_pkg::HalfW-1:0];
        end
        sard_pkg::CfgChannel: begin
          cfg_d.channel = cfg_data_i[sard_pkg::ChanW-1:0];
        end
        default: begin
          // Writes to an index beyond the register list have no effect.
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.half_period_ticks <= sard_pkg::ResetHalfPeriod;
      cfg_q.channel           <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/sard_seq.sv
// Pin sequencer of the serial ADC sample reader. It handles one tick per step.
// It depends on sard_pkg. It returns the result item built from the next state.
`timescale 1ns / 1ps

module sard_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  sard_pkg::in_item_t  item_i,
  input  sard_pkg::cfg_t      cfg_i,
  output sard_pkg::out_item_t result_o
);

  localparam logic [1:0] PhIdle = 2'd0;
  localparam logic [1:0] PhLead = 2'd1;
  localparam logic [1:0] PhHigh = 2'd2;
  localparam logic [1:0] PhLow  = 2'd3;

  localparam logic [sard_pkg::ClkIdxW-1:0] CmdClocks =
    sard_pkg::ClkIdxW'(sard_pkg::CommandClocks);
  localparam logic [sard_pkg::ClkIdxW-1:0] AllClocks =
    sard_pkg::ClkIdxW'(sard_pkg::TotalClocks);

  logic [1:0]                     phase_q, phase_d;
  logic [sard_pkg::ClkIdxW-1:0]   clk_idx_q, clk_idx_d;
  logic [sard_pkg::HalfW-1:0]     tick_q, tick_d;
  logic [sard_pkg::SampleW-1:0]   shift_q, shift_d;
  logic [sard_pkg::SampleW-1:0]   result_q, result_d;
  logic                           sclk_q, sclk_d;
  logic                           mosi_q, mosi_d;
  logic                           sel_q, sel_d;

  logic                           done;
  logic [sard_pkg::HalfW-1:0]     limit;
  logic [sard_pkg::HalfW-1:0]     tick_inc;
  logic [sard_pkg::ClkIdxW-1:0]   clk_idx_inc;
  logic                           cmd_bit;

  // A zero half period behaves like a half period of one tick.
  assign limit       = (cfg_i.half_period_ticks == '0) ? sard_pkg::HalfW'(1)
                                                        : cfg_i.half_period_ticks;
  assign tick_inc    = tick_q + sard_pkg::HalfW'(1);
  assign clk_idx_inc = clk_idx_q + sard_pkg::ClkIdxW'(1);

  // Command bits are start, single-ended and the channel, MSB first. Any later
  // command clock leaves the data pin as it is.
  always_comb begin
    case (clk_idx_q)
      5'd0:    cmd_bit = 1'b1;
      5'd1:    cmd_bit = 1'b1;
      5'd2:    cmd_bit = cfg_i.channel[2];
      5'd3:    cmd_bit = cfg_i.channel[1];
      5'd4:    cmd_bit = cfg_i.channel[0];
      default: cmd_bit = mosi_q;
    endcase
  end

  always_comb begin
    phase_d   = phase_q;
    clk_idx_d = clk_idx_q;
    tick_d    = tick_q;
    shift_d   = shift_q;
    result_d  = result_q;
    sclk_d    = sclk_q;
    mosi_d    = mosi_q;
    sel_d     = sel_q;
    done      = 1'b0;
    if (step_i) begin
      if (phase_q == PhIdle) begin
        if (item_i.start_req) begin
          sel_d     = 1'b0;
          sclk_d    = 1'b0;
          shift_d   = '0;
          clk_idx_d = '0;
          tick_d    = '0;
          phase_d   = PhLead;
        end
      end else begin
        tick_d = tick_inc;
        if (tick_inc >= limit) begin
          tick_d = '0;
          case (phase_q)
            PhLead: begin
              sclk_d    = 1'b1;
              clk_idx_d = '0;
              phase_d   = PhHigh;
            end
            PhHigh: begin
              if (clk_idx_q < CmdClocks) begin
                mosi_d = cmd_bit;
              end else if (clk_idx_q > CmdClocks) begin
                shift_d = {shift_q[sard_pkg::SampleW-2:0], item_i.miso_level};
              end
              sclk_d  = 1'b0;
              phase_d = PhLow;
            end
            default: begin
              if (clk_idx_inc >= AllClocks) begin
                sel_d     = 1'b1;
                result_d  = shift_q;
                done      = 1'b1;
                clk_idx_d = '0;
                phase_d   = PhIdle;
              end else begin
                clk_idx_d = clk_idx_inc;
                sclk_d    = 1'b1;
                phase_d   = PhHigh;
              end
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhIdle;
      clk_idx_q <= '0;
      tick_q    <= '0;
      shift_q   <= '0;
      result_q  <= '0;
      sclk_q    <= 1'b1;
      mosi_q    <= 1'b0;
      sel_q     <= 1'b1;
    end else begin
      phase_q   <= phase_d;
      clk_idx_q <= clk_idx_d;
      tick_q    <= tick_d;
      shift_q   <= shift_d;
      result_q  <= result_d;
      sclk_q    <= sclk_d;
      mosi_q    <= mosi_d;
      sel_q     <= sel_d;
    end
  end

  assign result_o.chip_select_n = sel_d;
  assign result_o.serial_clock  = sclk_d;
  assign result_o.mosi_level    = mosi_d;
  assign result_o.busy_res      = (phase_d != PhIdle);
  assign result_o.done_res      = done;
  assign result_o.sample        = result_d;

endmodule

FILE: rtl/spi_adc_sample_reader_core.sv
// Top level of the serial ADC sample reader.
// It depends on sard_pkg and instantiates sard_cfg and sard_seq.
`timescale 1ns / 1ps

// Each input request is one timer tick. It carries a start request and the
// sampled level of the converter's data output. Each tick gives exactly one
// result request: the chip select, serial clock and data pin levels, the busy
// and done flags, and the last 12-bit sample. A start drops chip select and
// the clock. After half a period, six command clocks send start,
// single-ended and the three channel bits. Then thirteen read clocks shift
// in the sample, MSB first, late in the high half of clocks two to thirteen.
// The block takes one tick every cycle while its output is not stalled. A tick
// passes through an input register, then the sequencer logic, then the result
// register, where it waits to be taken. The input register moves forward
// whenever the result register is empty or is being taken. A stall on the
// output therefore reaches the input in the same cycle, and no tick is dropped.
// The configuration registers are half_period_ticks (index 0) and channel
// (index 1). A write to any other index is ignored.

module spi_adc_sample_reader_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sard_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [sard_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  sard_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output sard_pkg::out_item_t           out_data_o
);

  sard_pkg::cfg_t      cfg;
  sard_pkg::in_item_t  in_data_q;
  sard_pkg::out_item_t out_data_q;
  sard_pkg::out_item_t step_result;
  logic                in_valid_q;
  logic                out_valid_q;
  logic                advance;
  logic                step;

  sard_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // The result register can take a new value when it is empty or being read.
  assign advance    = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_data_q <= in_data_i;
    end
  end

  sard_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (in_data_q),
    .cfg_i    (cfg),
    .result_o (step_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_data_q <= step_result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

FILE: rtl/sard_checker.sv
// Port-level checker for the serial ADC sample reader, and its bind.
// It depends on sard_pkg and on the ports of spi_adc_sample_reader_core.
`timescale 1ns / 1ps

module sard_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input sard_pkg::out_item_t out_data_o
);

  // A stalled result holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // Chip select is low exactly while a transfer is in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.chip_select_n == !out_data_o.busy_res))
    else $error("chip select does not match busy");

  // A finished transfer leaves the block idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.done_res |-> !out_data_o.busy_res)
    else $error("done while still busy");

endmodule

bind spi_adc_sample_reader_core sard_checker u_sard_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
